>>> src/sgrmb_pkg.sv
// Shared types, constants and helpers for the scaled glyph row mask blitter.
package sgrmb_pkg;

    localparam int MAX_GLYPH_ROWS = 8;
    localparam int MAX_GLYPH_COLS = 8;
    localparam int MAX_SCALE      = 8;
    localparam int LINE_STRIDE    = 1024;

    localparam int BITS_W  = 64;
    localparam int SIZE_W  = 4;
    localparam int NIB_W   = 4;
    localparam int COORD_W = 10;
    localparam int LINE_W  = 11;
    localparam int WORD_W  = 24;
    localparam int IDX_W   = 6;
    localparam int SCNT_W  = 3;
    localparam int TOTAL_W = 7;
    localparam int PROD_W  = 8;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic load;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic last;
    } t_dp_sts;

    function automatic logic [SIZE_W-1:0] sat_size(input logic [SIZE_W-1:0] v,
                                                   input int maxv);
        logic [SIZE_W-1:0] m;
        m = SIZE_W'(maxv);
        return (v > m) ? m : v;
    endfunction

endpackage

>>> src/sgrmb_ctrl.sv
// Controller state machine: request intake, span sequencing and output valid.
module sgrmb_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    input  sgrmb_pkg::t_dp_sts  i_sts,
    output sgrmb_pkg::t_dp_cmd  o_cmd
);

    sgrmb_pkg::t_state r_state;
    sgrmb_pkg::t_state n_state;
    logic              r_out_valid;
    logic              n_out_valid;
    logic              w_accept;
    logic              w_can_emit;

    assign w_accept   = i_in_valid && (r_state == sgrmb_pkg::ST_IDLE);
    assign w_can_emit = (r_state == sgrmb_pkg::ST_RUN) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sgrmb_pkg::ST_IDLE: begin
                if (w_accept && !i_sts.empty) begin
                    n_state = sgrmb_pkg::ST_RUN;
                end
            end
            sgrmb_pkg::ST_RUN: begin
                if (w_can_emit && i_sts.last) begin
                    n_state = sgrmb_pkg::ST_IDLE;
                end
            end
            default: n_state = sgrmb_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall  = 1'b1;
        o_cmd.load  = 1'b0;
        o_cmd.emit  = 1'b0;
        unique case (r_state)
            sgrmb_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = w_accept && !i_sts.empty;
            end
            sgrmb_pkg::ST_RUN: begin
                o_cmd.emit = w_can_emit;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

    always_comb begin
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sgrmb_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit && i_sts.last |=> r_state == sgrmb_pkg::ST_IDLE)
        else $error("last span did not return to idle");
    a_load_to_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == sgrmb_pkg::ST_RUN)
        else $error("loaded request did not start expansion");
    a_valid_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall && !o_cmd.emit |=> r_out_valid)
        else $error("stalled span was dropped");
    a_emit_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> r_state == sgrmb_pkg::ST_RUN && !o_cmd.load)
        else $error("span emitted outside expansion");
`endif

endmodule

>>> src/sgrmb_dp.sv
// Datapath: held request, span counters, row mask expansion and output registers.
module sgrmb_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sgrmb_pkg::t_dp_cmd                  i_cmd,
    output sgrmb_pkg::t_dp_sts                  o_sts,
    input  logic [sgrmb_pkg::BITS_W-1:0]        i_glyph_bits,
    input  logic [sgrmb_pkg::SIZE_W-1:0]        i_glyph_rows,
    input  logic [sgrmb_pkg::SIZE_W-1:0]        i_glyph_cols,
    input  logic [sgrmb_pkg::SIZE_W-1:0]        i_scale_factor,
    input  logic [sgrmb_pkg::NIB_W-1:0]         i_red_level,
    input  logic [sgrmb_pkg::NIB_W-1:0]         i_green_level,
    input  logic [sgrmb_pkg::NIB_W-1:0]         i_blue_level,
    input  logic [sgrmb_pkg::COORD_W-1:0]       i_origin_x,
    input  logic [sgrmb_pkg::COORD_W-1:0]       i_origin_y,
    input  logic                                i_buffer_select,
    output logic [sgrmb_pkg::LINE_W-1:0]        o_line_y,
    output logic [sgrmb_pkg::COORD_W-1:0]       o_span_x,
    output logic [sgrmb_pkg::BITS_W-1:0]        o_pixel_mask,
    output logic [sgrmb_pkg::WORD_W-1:0]        o_pixel_word,
    output logic                                o_target_buffer,
    output logic                                o_last_line
);

    logic [sgrmb_pkg::SIZE_W-1:0]  w_rows;
    logic [sgrmb_pkg::SIZE_W-1:0]  w_cols;
    logic [sgrmb_pkg::SIZE_W-1:0]  w_sc;
    logic [sgrmb_pkg::PROD_W-1:0]  w_rc;
    logic [sgrmb_pkg::PROD_W-1:0]  w_tot;

    logic [sgrmb_pkg::BITS_W-1:0]  r_bits;
    logic [sgrmb_pkg::SIZE_W-1:0]  r_rows;
    logic [sgrmb_pkg::SIZE_W-1:0]  r_cols;
    logic [sgrmb_pkg::SIZE_W-1:0]  r_sc;
    logic [sgrmb_pkg::WORD_W-1:0]  r_word;
    logic [sgrmb_pkg::COORD_W-1:0] r_ox;
    logic [sgrmb_pkg::COORD_W-1:0] r_oy;
    logic                          r_sel;
    logic [sgrmb_pkg::TOTAL_W-1:0] r_total;
    logic [sgrmb_pkg::IDX_W-1:0]   r_base;
    logic [sgrmb_pkg::IDX_W-1:0]   r_line;
    logic [sgrmb_pkg::SCNT_W-1:0]  r_scnt;

    logic [sgrmb_pkg::LINE_W-1:0]  r_o_line_y;
    logic [sgrmb_pkg::COORD_W-1:0] r_o_span_x;
    logic [sgrmb_pkg::BITS_W-1:0]  r_o_mask;
    logic [sgrmb_pkg::WORD_W-1:0]  r_o_word;
    logic                          r_o_tbuf;
    logic                          r_o_last;

    logic                          w_last;
    logic                          w_row_done;
    logic [sgrmb_pkg::BITS_W-1:0]  w_rep;
    logic [sgrmb_pkg::BITS_W-1:0]  w_mask;
    logic [sgrmb_pkg::IDX_W-1:0]   w_pos [sgrmb_pkg::MAX_GLYPH_COLS];
    logic [sgrmb_pkg::IDX_W-1:0]   w_off [sgrmb_pkg::MAX_GLYPH_COLS];

    assign w_rows = sgrmb_pkg::sat_size(i_glyph_rows, sgrmb_pkg::MAX_GLYPH_ROWS);
    assign w_cols = sgrmb_pkg::sat_size(i_glyph_cols, sgrmb_pkg::MAX_GLYPH_COLS);
    assign w_sc   = sgrmb_pkg::sat_size(i_scale_factor, sgrmb_pkg::MAX_SCALE);
    assign w_rc   = {4'd0, w_rows} * {4'd0, w_cols};
    assign w_tot  = {4'd0, w_rows} * {4'd0, w_sc};

    assign o_sts.empty = (w_rows == '0) || (w_cols == '0) || (w_sc == '0);
    assign w_last      = ({1'b0, r_line} + 7'd1) == r_total;
    assign o_sts.last  = w_last;
    assign w_row_done  = ({1'b0, r_scnt} + 4'd1) == r_sc;

    always_comb begin
        w_rep  = (64'd1 << r_sc) - 64'd1;
        w_mask = '0;
        for (int c = 0; c < sgrmb_pkg::MAX_GLYPH_COLS; c++) begin
            w_pos[c] = r_base - (6'(c) * 6'(r_rows));
            w_off[c] = 6'(c) * 6'(r_sc);
            if ((4'(c) < r_cols) && r_bits[w_pos[c]]) begin
                w_mask = w_mask | (w_rep << w_off[c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bits  <= i_glyph_bits;
            r_rows  <= w_rows;
            r_cols  <= w_cols;
            r_sc    <= w_sc;
            r_word  <= {i_red_level, 4'd0, i_green_level, 4'd0, i_blue_level, 4'd0};
            r_ox    <= i_origin_x;
            r_oy    <= i_origin_y;
            r_sel   <= i_buffer_select;
            r_total <= w_tot[sgrmb_pkg::TOTAL_W-1:0];
            r_base  <= w_rc[sgrmb_pkg::IDX_W-1:0] - 6'd1;
        end else if (i_cmd.emit && !w_last && w_row_done) begin
            r_base  <= r_base - 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line <= '0;
            r_scnt <= '0;
        end else if (i_cmd.load) begin
            r_line <= '0;
            r_scnt <= '0;
        end else if (i_cmd.emit) begin
            if (w_last) begin
                r_line <= '0;
                r_scnt <= '0;
            end else begin
                r_line <= r_line + 6'd1;
                r_scnt <= w_row_done ? '0 : r_scnt + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_line_y <= {1'b0, r_oy} + {5'd0, r_line};
            r_o_span_x <= r_ox;
            r_o_mask   <= w_mask;
            r_o_word   <= r_word;
            r_o_tbuf   <= r_sel;
            r_o_last   <= w_last;
        end
    end

    assign o_line_y        = r_o_line_y;
    assign o_span_x        = r_o_span_x;
    assign o_pixel_mask    = r_o_mask;
    assign o_pixel_word    = r_o_word;
    assign o_target_buffer = r_o_tbuf;
    assign o_last_line     = r_o_last;

endmodule

>>> src/scaled_glyph_row_mask_blitter_top.sv
// Top level of the scaled glyph row mask blitter: controller plus datapath.
//
// Each draw-character request expands into rows*scale spans (1 to 64), one span
// per clock from the span counter in the datapath while the output is not
// stalled, and the input is stalled during that expansion. Sizes above 8
// saturate to 8. A request with zero rows, columns or scale is taken and
// produces no span. Each span carries its screen y, the origin x, a
// pixel mask with each glyph cell repeated scale times (column 0 at bit 0), the
// packed color word and the buffer select; last_line marks the final span.
// There is no clipping, and frame-buffer addressing is left to the writer.
module scaled_glyph_row_mask_blitter_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [sgrmb_pkg::BITS_W-1:0]        i_glyph_bits,
    input  logic [sgrmb_pkg::SIZE_W-1:0]        i_glyph_rows,
    input  logic [sgrmb_pkg::SIZE_W-1:0]        i_glyph_cols,
    input  logic [sgrmb_pkg::SIZE_W-1:0]        i_scale_factor,
    input  logic [sgrmb_pkg::NIB_W-1:0]         i_red_level,
    input  logic [sgrmb_pkg::NIB_W-1:0]         i_green_level,
    input  logic [sgrmb_pkg::NIB_W-1:0]         i_blue_level,
    input  logic [sgrmb_pkg::COORD_W-1:0]       i_origin_x,
    input  logic [sgrmb_pkg::COORD_W-1:0]       i_origin_y,
    input  logic                                i_buffer_select,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [sgrmb_pkg::LINE_W-1:0]        o_line_y,
    output logic [sgrmb_pkg::COORD_W-1:0]       o_span_x,
    output logic [sgrmb_pkg::BITS_W-1:0]        o_pixel_mask,
    output logic [sgrmb_pkg::WORD_W-1:0]        o_pixel_word,
    output logic                                o_target_buffer,
    output logic                                o_last_line
);

    sgrmb_pkg::t_dp_cmd w_cmd;
    sgrmb_pkg::t_dp_sts w_sts;

    sgrmb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    sgrmb_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_glyph_bits    (i_glyph_bits),
        .i_glyph_rows    (i_glyph_rows),
        .i_glyph_cols    (i_glyph_cols),
        .i_scale_factor  (i_scale_factor),
        .i_red_level     (i_red_level),
        .i_green_level   (i_green_level),
        .i_blue_level    (i_blue_level),
        .i_origin_x      (i_origin_x),
        .i_origin_y      (i_origin_y),
        .i_buffer_select (i_buffer_select),
        .o_line_y        (o_line_y),
        .o_span_x        (o_span_x),
        .o_pixel_mask    (o_pixel_mask),
        .o_pixel_word    (o_pixel_word),
        .o_target_buffer (o_target_buffer),
        .o_last_line     (o_last_line)
    );

endmodule

>>> sim/glyph_span_checker.sv
// Span checker for the glyph blitter: expands each accepted request and compares the spans.
module glyph_span_checker
    import sgrmb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [BITS_W-1:0]  i_glyph_bits,
    input  logic [SIZE_W-1:0]  i_glyph_rows,
    input  logic [SIZE_W-1:0]  i_glyph_cols,
    input  logic [SIZE_W-1:0]  i_scale_factor,
    input  logic [NIB_W-1:0]   i_red_level,
    input  logic [NIB_W-1:0]   i_green_level,
    input  logic [NIB_W-1:0]   i_blue_level,
    input  logic [COORD_W-1:0] i_origin_x,
    input  logic [COORD_W-1:0] i_origin_y,
    input  logic               i_buffer_select,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [LINE_W-1:0]  i_line_y,
    input  logic [COORD_W-1:0] i_span_x,
    input  logic [BITS_W-1:0]  i_pixel_mask,
    input  logic [WORD_W-1:0]  i_pixel_word,
    input  logic               i_target_buffer,
    input  logic               i_last_line,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [LINE_W-1:0]  line_y;
        logic [COORD_W-1:0] span_x;
        logic [BITS_W-1:0]  pixel_mask;
        logic [WORD_W-1:0]  pixel_word;
        logic               target_buffer;
        logic               last_line;
    } t_span;

    t_span span_queue[$];
    int    fail_count = 0;

    function automatic int clamp_size(logic [SIZE_W-1:0] v, int maxv);
        return (int'(v) > maxv) ? maxv : int'(v);
    endfunction

    function automatic logic [BITS_W-1:0] replicate_row(logic [BITS_W-1:0] bits, int rows,
                                                        int cols, int sc, int row);
        logic [BITS_W-1:0] m;
        int                pos;
        m = '0;
        for (int c = 0; c < cols; c++) begin
            pos = rows * cols - c * rows - row - 1;
            if (bits[pos]) begin
                for (int k = 0; k < sc; k++) begin
                    m[c * sc + k] = 1'b1;
                end
            end
        end
        return m;
    endfunction

    function automatic int field_differs(string name, logic [BITS_W-1:0] exp_v,
                                         logic [BITS_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: span %s mismatch, expected %h actual %h", $realtime, name,
                     exp_v, act_v);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin : watch
        int    rows;
        int    cols;
        int    sc;
        t_span s;
        if (i_rst_n && i_in_valid && !i_in_stall) begin
            rows = clamp_size(i_glyph_rows, MAX_GLYPH_ROWS);
            cols = clamp_size(i_glyph_cols, MAX_GLYPH_COLS);
            sc   = clamp_size(i_scale_factor, MAX_SCALE);
            if (rows != 0 && cols != 0 && sc != 0) begin
                for (int n = 0; n < rows * sc; n++) begin
                    s.line_y        = LINE_W'(int'(i_origin_y) + n);
                    s.span_x        = i_origin_x;
                    s.pixel_mask    = replicate_row(i_glyph_bits, rows, cols, sc, n / sc);
                    s.pixel_word    = {i_red_level, 4'h0, i_green_level, 4'h0,
                                       i_blue_level, 4'h0};
                    s.target_buffer = i_buffer_select;
                    s.last_line     = (n == rows * sc - 1);
                    span_queue.push_back(s);
                end
            end
        end
        if (i_rst_n && i_out_valid && !i_out_stall) begin
            if (span_queue.size() == 0) begin
                $display("%0t: unexpected span, expected none actual y=%h x=%h mask=%h",
                         $realtime, i_line_y, i_span_x, i_pixel_mask);
                fail_count++;
            end else begin
                s = span_queue.pop_front();
                fail_count += field_differs("line_y", BITS_W'(s.line_y), BITS_W'(i_line_y));
                fail_count += field_differs("span_x", BITS_W'(s.span_x), BITS_W'(i_span_x));
                fail_count += field_differs("pixel_mask", s.pixel_mask, i_pixel_mask);
                fail_count += field_differs("pixel_word", BITS_W'(s.pixel_word),
                                            BITS_W'(i_pixel_word));
                fail_count += field_differs("target_buffer", BITS_W'(s.target_buffer),
                                            BITS_W'(i_target_buffer));
                fail_count += field_differs("last_line", BITS_W'(s.last_line),
                                            BITS_W'(i_last_line));
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= span_queue.size();
    end

endmodule

>>> sim/scaled_glyph_row_mask_blitter_top_tb.sv
// Testbench top for the glyph blitter: clock, reset, request stimulus and verdict.
module scaled_glyph_row_mask_blitter_top_tb;
    import sgrmb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 300000;

    typedef struct {
        logic [BITS_W-1:0]  bits;
        logic [SIZE_W-1:0]  rows;
        logic [SIZE_W-1:0]  cols;
        logic [SIZE_W-1:0]  sc;
        logic [NIB_W-1:0]   red;
        logic [NIB_W-1:0]   green;
        logic [NIB_W-1:0]   blue;
        logic [COORD_W-1:0] ox;
        logic [COORD_W-1:0] oy;
        logic               sel;
    } t_request;

    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               in_valid        = 1'b0;
    logic               in_stall;
    logic [BITS_W-1:0]  glyph_bits      = '0;
    logic [SIZE_W-1:0]  glyph_rows      = '0;
    logic [SIZE_W-1:0]  glyph_cols      = '0;
    logic [SIZE_W-1:0]  scale_factor    = '0;
    logic [NIB_W-1:0]   red_level       = '0;
    logic [NIB_W-1:0]   green_level     = '0;
    logic [NIB_W-1:0]   blue_level      = '0;
    logic [COORD_W-1:0] origin_x        = '0;
    logic [COORD_W-1:0] origin_y        = '0;
    logic               buffer_select   = 1'b0;
    logic               out_valid;
    logic               out_stall       = 1'b0;
    logic [LINE_W-1:0]  line_y;
    logic [COORD_W-1:0] span_x;
    logic [BITS_W-1:0]  pixel_mask;
    logic [WORD_W-1:0]  pixel_word;
    logic               target_buffer;
    logic               last_line;

    int fail_count;
    int pending;
    int in_idle_pct  = 0;
    int out_idle_pct = 0;
    int cycle_count  = 0;

    scaled_glyph_row_mask_blitter_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_glyph_bits    (glyph_bits),
        .i_glyph_rows    (glyph_rows),
        .i_glyph_cols    (glyph_cols),
        .i_scale_factor  (scale_factor),
        .i_red_level     (red_level),
        .i_green_level   (green_level),
        .i_blue_level    (blue_level),
        .i_origin_x      (origin_x),
        .i_origin_y      (origin_y),
        .i_buffer_select (buffer_select),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_line_y        (line_y),
        .o_span_x        (span_x),
        .o_pixel_mask    (pixel_mask),
        .o_pixel_word    (pixel_word),
        .o_target_buffer (target_buffer),
        .o_last_line     (last_line)
    );

    glyph_span_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_glyph_bits    (glyph_bits),
        .i_glyph_rows    (glyph_rows),
        .i_glyph_cols    (glyph_cols),
        .i_scale_factor  (scale_factor),
        .i_red_level     (red_level),
        .i_green_level   (green_level),
        .i_blue_level    (blue_level),
        .i_origin_x      (origin_x),
        .i_origin_y      (origin_y),
        .i_buffer_select (buffer_select),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_line_y        (line_y),
        .i_span_x        (span_x),
        .i_pixel_mask    (pixel_mask),
        .i_pixel_word    (pixel_word),
        .i_target_buffer (target_buffer),
        .i_last_line     (last_line),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(0, 99) < out_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic t_request make_request(logic [BITS_W-1:0] bits, int rows, int cols,
                                              int sc, int red, int green, int blue,
                                              int ox, int oy, bit sel);
        t_request q;
        q.bits  = bits;
        q.rows  = SIZE_W'(rows);
        q.cols  = SIZE_W'(cols);
        q.sc    = SIZE_W'(sc);
        q.red   = NIB_W'(red);
        q.green = NIB_W'(green);
        q.blue  = NIB_W'(blue);
        q.ox    = COORD_W'(ox);
        q.oy    = COORD_W'(oy);
        q.sel   = sel;
        return q;
    endfunction

    // mostly small drawable sizes, some empty, some oversized
    function automatic int pick_size();
        int p;
        p = $urandom_range(0, 99);
        if (p < 5) begin
            return 0;
        end else if (p < 12) begin
            return $urandom_range(9, 15);
        end else if (p < 80) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(5, 8);
    endfunction

    function automatic t_request random_request();
        return make_request({$urandom, $urandom}, pick_size(), pick_size(), pick_size(),
                            $urandom_range(0, 15), $urandom_range(0, 15),
                            $urandom_range(0, 15), $urandom_range(0, 1023),
                            $urandom_range(0, 1023), $urandom_range(0, 1));
    endfunction

    task automatic issue(input t_request q);
        if (in_idle_pct > 0 && $urandom_range(0, 99) < in_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        in_valid      <= 1'b1;
        glyph_bits    <= q.bits;
        glyph_rows    <= q.rows;
        glyph_cols    <= q.cols;
        scale_factor  <= q.sc;
        red_level     <= q.red;
        green_level   <= q.green;
        blue_level    <= q.blue;
        origin_x      <= q.ox;
        origin_y      <= q.oy;
        buffer_select <= q.sel;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
    endtask

    task automatic drain_spans();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic run_random(input int drawn_count);
        t_request q;
        int       drawn;
        drawn = 0;
        while (drawn < drawn_count) begin
            q = random_request();
            issue(q);
            if (q.rows != 0 && q.cols != 0 && q.sc != 0) begin
                drawn++;
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n      <= 1'b1;
        in_idle_pct  = 19;
        out_idle_pct = 67;

        issue(make_request('1, 8, 8, 8, 15, 15, 15, 1023, 1023, 1'b1));
        issue(make_request(64'h1, 1, 1, 1, 0, 0, 0, 0, 0, 1'b0));
        issue(make_request('1, 0, 4, 2, 3, 4, 5, 10, 20, 1'b1));
        issue(make_request('1, 4, 0, 2, 3, 4, 5, 10, 20, 1'b0));
        issue(make_request('1, 4, 4, 0, 3, 4, 5, 10, 20, 1'b1));
        issue(make_request(64'hDEAD_BEEF_0123_4567, 15, 15, 15, 9, 6, 3, 512, 1000, 1'b0));
        issue(make_request(64'hF0F0_0F0F_3C3C_C3C3, 9, 8, 1, 1, 2, 3, 1023, 0, 1'b1));
        issue(make_request(64'h0, 8, 8, 2, 15, 0, 0, 0, 1023, 1'b0));
        issue(make_request(64'hFFFF_FFFF_FFFF_FFC5, 3, 2, 3, 0, 15, 0, 100, 200, 1'b1));
        issue(make_request(64'hAAAA_AAAA_AAAA_AAAA, 8, 8, 1, 0, 0, 15, 300, 400, 1'b0));
        issue(make_request(64'h5555_5555_5555_5555, 8, 8, 1, 15, 15, 15, 700, 800, 1'b1));
        issue(make_request(64'h0000_0000_0000_00A5, 8, 1, 8, 5, 10, 5, 1023, 1023, 1'b0));
        issue(make_request(64'h0000_0000_0000_00C3, 1, 8, 8, 10, 5, 10, 0, 0, 1'b1));
        issue(make_request(64'h8000_0000_0000_0001, 8, 8, 1, 7, 8, 9, 511, 512, 1'b0));
        issue(make_request(64'h0000_0000_0000_0009, 2, 2, 12, 12, 13, 14, 1, 1022, 1'b1));
        issue(make_request(64'h1234_5678_9ABC_DEF0, 7, 5, 3, 15, 15, 15, 1023, 1023, 1'b1));

        run_random(50);
        drain_spans();
        in_idle_pct  = 67;
        out_idle_pct = 19;
        run_random(50);
        drain_spans();
        in_idle_pct  = 0;
        out_idle_pct = 0;
        run_random(50);
        drain_spans();
        repeat (16) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
